[rtl/core/gbld_pkg.sv]
// gbld_pkg: constants, result type and crc helper for the gnss binary log deframer
// no dependencies; imported by the top level and the checker
package gbld_pkg;

   // sync pattern
   localparam logic [7:0] SYNC_A = 8'hAA;
   localparam logic [7:0] SYNC_B = 8'h44;
   localparam logic [7:0] SYNC_C = 8'h12;

   // message identifiers that carry captured values
   localparam logic [15:0] ID_POSITION = 16'd42;
   localparam logic [15:0] ID_VELOCITY = 16'd99;

   // offsets of the first captured word after the header
   localparam logic [8:0] POS_OFFSET = 9'd8;
   localparam logic [8:0] VEL_OFFSET = 9'd16;

   // event codes
   localparam int EVENT_W = 3;
   localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
   localparam logic [EVENT_W-1:0] EV_POSITION = 3'd1;
   localparam logic [EVENT_W-1:0] EV_VELOCITY = 3'd2;
   localparam logic [EVENT_W-1:0] EV_CRC_FAIL = 3'd3;
   localparam logic [EVENT_W-1:0] EV_TOO_LONG = 3'd4;

   // reflected crc-32
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [63:0]        first_value;
      logic [63:0]        second_value;
      logic [15:0]        message_id;
   } gbld_result_type;

   // one byte of the reflected crc, lsb first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_i, input logic [7:0] b_i);
      logic [31:0] c;
      c = crc_i ^ {24'd0, b_i};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // crc after the three sync bytes, from zero
   localparam logic [31:0] SYNC_CRC = crc_byte(crc_byte(crc_byte(32'd0, SYNC_A), SYNC_B), SYNC_C);

endpackage

[rtl/core/gbld_req_if.sv]
// gbld_req_if: byte input channel of the deframer
// no dependencies
interface gbld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/core/gbld_rsp_if.sv]
// gbld_rsp_if: result channel of the deframer
// no dependencies
interface gbld_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [63:0] first_value;
   logic [63:0] second_value;
   logic [15:0] message_id;

   modport source (output valid, output event_res, output first_value,
                   output second_value, output message_id, input ready);
   modport sink (input valid, input event_res, input first_value,
                 input second_value, input message_id, output ready);
endinterface

[rtl/core/gbld_csr_if.sv]
// gbld_csr_if: write channel for the capture enable register
// no dependencies
interface gbld_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/core/gnss_binary_log_deframer_top.sv]
// Deframer for binary gnss logs: takes one received byte per word and gives one result word
// for each. It hunts for the sync AA 44 12, reads header length, message id and message
// length, runs a reflected crc-32 (init 0) over the whole frame and, at the frame end,
// reports a position frame (id 42), a velocity frame (id 99), a crc failure or, when the
// byte count reaches MAX_FRAME, a frame that is too long. The byte-wide crc update and
// field capture sit between the frame state registers and a two-deep result buffer, so a
// byte can be taken in every cycle while the sink keeps up, and up to two results wait
// when it stalls. Depends on gbld_pkg and the gbld interfaces.
module gnss_binary_log_deframer_top #(
   parameter int MAX_FRAME = 256
) (
   input logic         clock,
   input logic         reset,
   gbld_req_if.sink    req_ch,
   gbld_rsp_if.source  rsp_ch,
   gbld_csr_if.sink    csr_ch
);
   import gbld_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int CMP_W = ((CNT_W > 17) ? CNT_W : 17) + 1;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAME);

   // configuration and frame state
   logic              cap_en_ff;
   logic [15:0]       sync_hist_ff, sync_hist_in;
   logic              active_ff, active_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        hdr_len_ff, hdr_len_in;
   logic [15:0]       msg_id_ff, msg_id_in;
   logic [15:0]       msg_len_ff, msg_len_in;
   logic [31:0]       crc_ff, crc_in;
   logic [63:0]       cap_first_ff, cap_first_in;
   logic [63:0]       cap_second_ff, cap_second_in;

   // result buffer
   logic              out_valid_ff, out_valid_in;
   gbld_result_type   out_ff, out_in;
   logic              skid_valid_ff, skid_valid_in;
   gbld_result_type   skid_ff, skid_in;

   logic              accept;
   gbld_result_type   res;
   logic              is_sync;
   logic [7:0]        b;
   logic [CNT_W-1:0]  cnt_next;
   logic [CMP_W-1:0]  pos_c, base_c, off_c, total_c, next_c;

   assign accept       = req_ch.valid & req_ch.ready;
   assign b            = req_ch.rx_byte;
   assign req_ch.ready = ~skid_valid_ff;
   assign csr_ch.ready = 1'b1;

   // capture enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_en_ff <= 1'b1;
      end else if (csr_ch.valid) begin
         cap_en_ff <= csr_ch.data;
      end
   end

   // frame parsing for one byte
   always_comb begin
      sync_hist_in  = sync_hist_ff;
      active_in     = active_ff;
      count_in      = count_ff;
      hdr_len_in    = hdr_len_ff;
      msg_id_in     = msg_id_ff;
      msg_len_in    = msg_len_ff;
      crc_in        = crc_ff;
      cap_first_in  = cap_first_ff;
      cap_second_in = cap_second_ff;
      res           = '0;
      is_sync       = (sync_hist_ff == {SYNC_A, SYNC_B}) && (b == SYNC_C);
      cnt_next      = count_ff + CNT_W'(1);
      pos_c         = CMP_W'(count_ff);
      base_c        = '0;
      off_c         = '0;
      total_c       = '0;
      next_c        = CMP_W'(cnt_next);
      if (accept && cap_en_ff) begin
         sync_hist_in = {sync_hist_ff[7:0], b};
         if (is_sync) begin
            // sync always restarts a frame
            active_in     = 1'b1;
            count_in      = CNT_W'(3);
            hdr_len_in    = '0;
            msg_id_in     = '0;
            msg_len_in    = '0;
            cap_first_in  = '0;
            cap_second_in = '0;
            crc_in        = SYNC_CRC;
         end else if (active_ff) begin
            crc_in = crc_byte(crc_ff, b);
            // header fields
            if (count_ff == CNT_W'(3)) begin
               hdr_len_in = b;
            end else if (count_ff == CNT_W'(4)) begin
               msg_id_in = {8'd0, b};
            end else if (count_ff == CNT_W'(5)) begin
               msg_id_in = msg_id_ff | {b, 8'd0};
            end else if (count_ff == CNT_W'(8)) begin
               msg_len_in = {8'd0, b};
            end else if (count_ff == CNT_W'(9)) begin
               msg_len_in = msg_len_ff | {b, 8'd0};
            end
            // body words of interest
            if ((pos_c >= CMP_W'(8)) && ((msg_id_in == ID_POSITION) ||
                                         (msg_id_in == ID_VELOCITY))) begin
               base_c = CMP_W'(hdr_len_in) +
                        CMP_W'((msg_id_in == ID_POSITION) ? POS_OFFSET : VEL_OFFSET);
               off_c  = pos_c - base_c;
               if ((pos_c >= base_c) && (pos_c < base_c + CMP_W'(8))) begin
                  cap_first_in[off_c[2:0]*8 +: 8] = cap_first_ff[off_c[2:0]*8 +: 8] | b;
               end else if ((pos_c >= base_c + CMP_W'(8)) &&
                            (pos_c < base_c + CMP_W'(16))) begin
                  cap_second_in[off_c[2:0]*8 +: 8] = cap_second_ff[off_c[2:0]*8 +: 8] | b;
               end
            end
            count_in = cnt_next;
            total_c  = CMP_W'(hdr_len_in) + CMP_W'(msg_len_in) + CMP_W'(4);
            // frame end or length limit
            if ((next_c >= CMP_W'(10)) && (next_c == total_c)) begin
               active_in = 1'b0;
               if (crc_in != 32'd0) begin
                  res.event_res  = EV_CRC_FAIL;
                  res.message_id = msg_id_in;
               end else if (msg_id_in == ID_POSITION || msg_id_in == ID_VELOCITY) begin
                  res.event_res    = (msg_id_in == ID_POSITION) ? EV_POSITION : EV_VELOCITY;
                  res.first_value  = cap_first_in;
                  res.second_value = cap_second_in;
                  res.message_id   = msg_id_in;
               end
            end else if (next_c >= MAX_CMP) begin
               active_in      = 1'b0;
               res.event_res  = EV_TOO_LONG;
               res.message_id = msg_id_in;
            end
         end
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_hist_ff  <= '0;
         active_ff     <= 1'b0;
         count_ff      <= '0;
         hdr_len_ff    <= '0;
         msg_id_ff     <= '0;
         msg_len_ff    <= '0;
         crc_ff        <= '0;
         cap_first_ff  <= '0;
         cap_second_ff <= '0;
      end else begin
         sync_hist_ff  <= sync_hist_in;
         active_ff     <= active_in;
         count_ff      <= count_in;
         hdr_len_ff    <= hdr_len_in;
         msg_id_ff     <= msg_id_in;
         msg_len_ff    <= msg_len_in;
         crc_ff        <= crc_in;
         cap_first_ff  <= cap_first_in;
         cap_second_ff <= cap_second_in;
      end
   end

   // output register with skid stage behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_ch.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = accept;
            skid_in       = res;
         end else begin
            out_valid_in = accept;
            out_in       = res;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.event_res    = out_ff.event_res;
   assign rsp_ch.first_value  = out_ff.first_value;
   assign rsp_ch.second_value = out_ff.second_value;
   assign rsp_ch.message_id   = out_ff.message_id;

endmodule

[rtl/core/gbld_checker.sv]
// gbld_checker: port-level checks on the deframer's result channel
// depends on gbld_pkg; bound to gnss_binary_log_deframer_top below
module gbld_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  event_res,
   input logic [63:0] first_value,
   input logic [63:0] second_value,
   input logic [15:0] message_id
);
   import gbld_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_res) &&
      $stable(first_value) && $stable(second_value) && $stable(message_id))
      else $error("result word changed while stalled");

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // values only accompany a good position or velocity frame
   a_values_only_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_res != EV_POSITION) && (event_res != EV_VELOCITY) |->
      (first_value == 64'd0) && (second_value == 64'd0))
      else $error("captured values on a frame that is not good");

   // no event carries no message id
   a_none_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_res == EV_NONE) |-> (message_id == 16'd0))
      else $error("message id without an event");

   // good frames carry their own id
   a_id_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_res == EV_POSITION || event_res == EV_VELOCITY) |->
      ((event_res == EV_POSITION) ? (message_id == ID_POSITION) : (message_id == ID_VELOCITY)))
      else $error("message id does not match event");

endmodule

bind gnss_binary_log_deframer_top gbld_checker u_gbld_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .event_res    (rsp_ch.event_res),
   .first_value  (rsp_ch.first_value),
   .second_value (rsp_ch.second_value),
   .message_id   (rsp_ch.message_id)
);

[tb/sv/gnss_binary_log_deframer_top_tb.sv]
`timescale 1ns / 1ps
// testbench for gnss_binary_log_deframer_top: feeds frames, noise and broken frames byte by byte
// and checks every result word against a local deframing predictor
// depends on gbld_pkg, the gbld interfaces and the deframer top level
module gnss_binary_log_deframer_top_tb;
   import gbld_pkg::*;

   localparam int FRAME_LIMIT = 256;

   logic clock;
   logic reset;

   gbld_req_if req_ch ();
   gbld_rsp_if rsp_ch ();
   gbld_csr_if csr_ch ();

   gnss_binary_log_deframer_top #(.MAX_FRAME(FRAME_LIMIT)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state, mirrors the frame registers of the deframer
   logic        capture_on;
   logic [15:0] hunt_history;
   logic        in_frame;
   logic [8:0]  frame_pos;
   logic [7:0]  hdr_len;
   logic [15:0] frame_id;
   logic [15:0] body_len;
   logic [31:0] frame_crc;
   logic [63:0] word_a;
   logic [63:0] word_b;

   gbld_result_type expected_results[$];
   logic [7:0]      frame_bytes[$];

   int error_count;
   int bytes_sent;
   int event_tally[0:7];
   bit req_gaps;
   bit rsp_gaps;
   int rsp_hold;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // one byte of reflected crc-32, lsb first
   function automatic logic [31:0] crc32_step(input logic [31:0] c_in, input logic [7:0] d);
      logic [31:0] c;
      logic        lsb;
      c = c_in ^ {24'd0, d};
      for (int k = 0; k < 8; k++) begin
         lsb = c[0];
         c   = {1'b0, c[31:1]};
         if (lsb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   // expected result word for one accepted byte, advances the predictor state
   function automatic gbld_result_type deframe_byte(input logic [7:0] b);
      gbld_result_type r;
      int unsigned     pos;
      int unsigned     base;
      int unsigned     total;
      logic            hit;
      r = '0;
      r.event_res = EV_NONE;
      if (!capture_on) return r;

      hit = (hunt_history == {SYNC_A, SYNC_B}) && (b == SYNC_C);
      hunt_history = {hunt_history[7:0], b};

      // sync always restarts a frame, even inside one
      if (hit) begin
         in_frame  = 1'b1;
         frame_pos = 9'd3;
         hdr_len   = '0;
         frame_id  = '0;
         body_len  = '0;
         word_a    = '0;
         word_b    = '0;
         frame_crc = crc32_step(crc32_step(crc32_step(32'd0, SYNC_A), SYNC_B), SYNC_C);
         return r;
      end
      if (!in_frame) return r;

      pos = frame_pos;
      frame_crc = crc32_step(frame_crc, b);

      // header fields
      case (pos)
         3: hdr_len = b;
         4: frame_id = {8'd0, b};
         5: frame_id[15:8] = b;
         8: body_len = {8'd0, b};
         9: body_len[15:8] = b;
         default: ;
      endcase

      // captured words for position and velocity logs
      if (pos >= 8 && (frame_id == ID_POSITION || frame_id == ID_VELOCITY)) begin
         base = int'(hdr_len) + ((frame_id == ID_POSITION) ? int'(POS_OFFSET) : int'(VEL_OFFSET));
         if (pos >= base && pos < base + 8)
            word_a = word_a | (64'(b) << (8 * (pos - base)));
         else if (pos >= base + 8 && pos < base + 16)
            word_b = word_b | (64'(b) << (8 * (pos - base - 8)));
      end

      frame_pos = 9'(pos + 1);
      total = int'(hdr_len) + int'(body_len) + 4;

      // end of frame only once the lengths are in
      if (pos + 1 >= 10 && pos + 1 == total) begin
         in_frame = 1'b0;
         if (frame_crc != 32'd0) begin
            r.event_res  = EV_CRC_FAIL;
            r.message_id = frame_id;
         end else if (frame_id == ID_POSITION || frame_id == ID_VELOCITY) begin
            r.event_res    = (frame_id == ID_POSITION) ? EV_POSITION : EV_VELOCITY;
            r.first_value  = word_a;
            r.second_value = word_b;
            r.message_id   = frame_id;
         end
         return r;
      end
      if (pos + 1 >= FRAME_LIMIT) begin
         in_frame     = 1'b0;
         r.event_res  = EV_TOO_LONG;
         r.message_id = frame_id;
      end
      return r;
   endfunction

   // result sink with random stalls and a counted hold-off
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else if (rsp_gaps) begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= 30);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin : check_word
      gbld_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word, event %0d id %0h", $time,
                     rsp_ch.event_res, rsp_ch.message_id);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            event_tally[want.event_res]++;
            if (rsp_ch.event_res !== want.event_res) begin
               $display("%0t: event_res expected %0d actual %0d", $time,
                        want.event_res, rsp_ch.event_res);
               error_count++;
            end
            if (rsp_ch.first_value !== want.first_value) begin
               $display("%0t: first_value expected %h actual %h", $time,
                        want.first_value, rsp_ch.first_value);
               error_count++;
            end
            if (rsp_ch.second_value !== want.second_value) begin
               $display("%0t: second_value expected %h actual %h", $time,
                        want.second_value, rsp_ch.second_value);
               error_count++;
            end
            if (rsp_ch.message_id !== want.message_id) begin
               $display("%0t: message_id expected %h actual %h", $time,
                        want.message_id, rsp_ch.message_id);
               error_count++;
            end
         end
      end
   end

   // offer one byte, with an optional idle gap first; valid stays high afterwards
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (req_gaps && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 2);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      expected_results.push_back(deframe_byte(b));
      bytes_sent++;
   endtask

   // send the first count bytes of frame_bytes
   task automatic send_frame_part(input int count);
      for (int i = 0; i < count && i < frame_bytes.size(); i++) send_byte(frame_bytes[i]);
   endtask

   // stop offering and wait for every outstanding result word
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic write_capture_enable(input logic en);
      drain_results();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= en;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      capture_on = en;
   endtask

   // well-formed frame in frame_bytes, the two words placed where the id wants them,
   // crc appended lsb first so the residue comes out zero; hlen must be at least 10
   task automatic build_frame(input logic [7:0] hlen, input logic [15:0] id,
                              input logic [15:0] blen, input logic [63:0] wa,
                              input logic [63:0] wb);
      int          n;
      int          base;
      logic [31:0] c;
      n = int'(hlen) + int'(blen);
      frame_bytes.delete();
      for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes[0] = SYNC_A;
      frame_bytes[1] = SYNC_B;
      frame_bytes[2] = SYNC_C;
      frame_bytes[3] = hlen;
      frame_bytes[4] = id[7:0];
      frame_bytes[5] = id[15:8];
      frame_bytes[8] = blen[7:0];
      frame_bytes[9] = blen[15:8];
      base = int'(hlen) + ((id == ID_POSITION) ? int'(POS_OFFSET) : int'(VEL_OFFSET));
      for (int i = 0; i < 16; i++)
         if (base + i < n) frame_bytes[base + i] = (i < 8) ? wa[8 * i +: 8] : wb[8 * (i - 8) +: 8];
      c = 32'd0;
      foreach (frame_bytes[i]) c = crc32_step(c, frame_bytes[i]);
      for (int i = 0; i < 4; i++) frame_bytes.push_back(c[8 * i +: 8]);
   endtask

   // header that never reaches its end, padded with filler up to len_total bytes
   task automatic build_runaway(input logic [7:0] hlen, input logic [15:0] id,
                                input logic [15:0] blen, input int len_total);
      frame_bytes.delete();
      frame_bytes.push_back(SYNC_A);
      frame_bytes.push_back(SYNC_B);
      frame_bytes.push_back(SYNC_C);
      frame_bytes.push_back(hlen);
      frame_bytes.push_back(id[7:0]);
      frame_bytes.push_back(id[15:8]);
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(blen[7:0]);
      frame_bytes.push_back(blen[15:8]);
      while (frame_bytes.size() < len_total) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // bytes outside a frame, near misses of the sync among them
   task automatic test_hunting();
      logic [7:0] noise[$];
      noise = '{8'h00, 8'hFF, SYNC_A, SYNC_B, 8'h13, SYNC_B, SYNC_C, SYNC_A, SYNC_A, SYNC_C};
      foreach (noise[i]) send_byte(noise[i]);
   endtask

   task automatic test_position_frame();
      build_frame(8'd10, ID_POSITION, 16'd24, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      send_frame_part(frame_bytes.size());
   endtask

   task automatic test_velocity_frame();
      build_frame(8'd10, ID_VELOCITY, 16'd32, {$urandom, $urandom}, 64'h8000_0000_0000_0001);
      send_frame_part(frame_bytes.size());
   endtask

   // valid crc but an id that carries nothing
   task automatic test_other_id();
      build_frame(8'd10, 16'hFFFF, 16'd0, 64'h0, 64'h0);
      send_frame_part(frame_bytes.size());
   endtask

   task automatic test_crc_failure();
      build_frame(8'd10, ID_POSITION, 16'd0, 64'h0, 64'h0);
      frame_bytes[frame_bytes.size() - 1] = frame_bytes[frame_bytes.size() - 1] ^ 8'h01;
      send_frame_part(frame_bytes.size());
   endtask

   // sync in the middle of a frame and on what would be its last byte
   task automatic test_sync_restart();
      build_frame(8'd10, ID_VELOCITY, 16'd32, {$urandom, $urandom}, {$urandom, $urandom});
      send_frame_part(15);
      build_frame(8'd10, ID_POSITION, 16'd24, {$urandom, $urandom}, {$urandom, $urandom});
      send_frame_part(frame_bytes.size());
      build_frame(8'd10, ID_POSITION, 16'd12, {$urandom, $urandom}, {$urandom, $urandom});
      send_frame_part(frame_bytes.size() - 3);
      build_frame(8'd10, ID_POSITION, 16'd12, {$urandom, $urandom}, {$urandom, $urandom});
      send_frame_part(frame_bytes.size());
   endtask

   // capture off holds the state, even halfway through a frame
   task automatic test_capture_disable();
      logic [7:0] keep[$];
      write_capture_enable(1'b0);
      send_byte(SYNC_A);
      send_byte(SYNC_B);
      send_byte(SYNC_C);
      send_byte(8'hFF);
      write_capture_enable(1'b1);
      build_frame(8'd10, ID_POSITION, 16'd24, {$urandom, $urandom}, {$urandom, $urandom});
      keep = frame_bytes;
      send_frame_part(20);
      write_capture_enable(1'b0);
      for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)));
      send_byte(SYNC_A);
      send_byte(SYNC_B);
      send_byte(SYNC_C);
      write_capture_enable(1'b1);
      for (int i = 20; i < keep.size(); i++) send_byte(keep[i]);
   endtask

   // declared total under ten runs into the frame limit, streamed with no idling
   task automatic test_length_limits();
      bit keep_req;
      bit keep_rsp;
      keep_req = req_gaps;
      keep_rsp = rsp_gaps;
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      build_runaway(8'd0, ID_POSITION, 16'd0, FRAME_LIMIT);
      send_frame_part(frame_bytes.size());
      req_gaps = keep_req;
      rsp_gaps = keep_rsp;
   endtask

   // sink holds off while a frame streams in, then the source waits for all results
   task automatic test_backpressure();
      rsp_hold = 80;
      build_frame(8'd10, ID_POSITION, 16'd24, {$urandom, $urandom}, {$urandom, $urandom});
      send_frame_part(frame_bytes.size());
      drain_results();
   endtask

   // mostly well-formed frames with random content, plus broken frames and noise
   task automatic test_random();
      int          stop_at;
      int          next_cfg;
      int          kind;
      int          pick;
      logic [7:0]  hlen;
      logic [15:0] blen;
      logic [15:0] id;
      stop_at  = bytes_sent + 80;
      next_cfg = bytes_sent + 30;
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      while (bytes_sent < stop_at) begin
         // idling back on after a quiet opening stretch; capture setting changes now and then
         if (bytes_sent >= next_cfg) begin
            req_gaps = 1'b1;
            rsp_gaps = 1'b1;
            write_capture_enable($urandom_range(0, 99) < 75);
            next_cfg = bytes_sent + 30;
         end
         kind = $urandom_range(0, 99);
         pick = $urandom_range(0, 99);
         hlen = 8'($urandom_range(10, 28));
         blen = 16'($urandom_range(0, 40));
         id   = (pick < 40) ? ID_POSITION :
                (pick < 80) ? ID_VELOCITY : 16'($urandom_range(0, 65535));
         if (kind < 60) begin
            build_frame(hlen, id, blen, {$urandom, $urandom}, {$urandom, $urandom});
            send_frame_part(frame_bytes.size());
         end else if (kind < 75) begin
            build_frame(hlen, id, blen, {$urandom, $urandom}, {$urandom, $urandom});
            pick = $urandom_range(3, frame_bytes.size() - 1);
            frame_bytes[pick] = frame_bytes[pick] ^ (8'd1 << $urandom_range(0, 7));
            send_frame_part(frame_bytes.size());
         end else if (kind < 85) begin
            build_frame(hlen, id, blen, {$urandom, $urandom}, {$urandom, $urandom});
            send_frame_part($urandom_range(1, frame_bytes.size() - 1));
         end else if (kind < 95) begin
            frame_bytes.delete();
            if (pick < 50) begin
               frame_bytes.push_back(SYNC_A);
               frame_bytes.push_back(SYNC_B);
            end
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            send_frame_part(frame_bytes.size());
         end else if (kind < 97) begin
            // header promising more than the limit, cut short
            build_runaway(8'($urandom_range(0, 255)), id, 16'($urandom_range(300, 65535)), 40);
            send_frame_part(frame_bytes.size());
         end else begin
            build_frame(8'd10, id, 16'd0, 64'h0, 64'h0);
            send_frame_part(frame_bytes.size());
         end
      end
      write_capture_enable(1'b1);
   endtask

   initial begin
      error_count = 0;
      bytes_sent  = 0;
      foreach (event_tally[i]) event_tally[i] = 0;
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      rsp_hold = 0;

      // predictor after reset
      capture_on   = 1'b1;
      hunt_history = '0;
      in_frame     = 1'b0;
      frame_pos    = '0;
      hdr_len      = '0;
      frame_id     = '0;
      body_len     = '0;
      frame_crc    = '0;
      word_a       = '0;
      word_b       = '0;

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.data    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_capture_enable(1'b1);
      test_hunting();
      test_position_frame();
      test_velocity_frame();
      test_other_id();
      test_crc_failure();
      test_sync_restart();
      test_capture_disable();
      test_length_limits();
      test_backpressure();
      test_random();

      drain_results();
      repeat (10) @(posedge clock);

      $display("sent %0d bytes: %0d position, %0d velocity, %0d crc failures, %0d over-length,",
               bytes_sent, event_tally[EV_POSITION], event_tally[EV_VELOCITY],
               event_tally[EV_CRC_FAIL], event_tally[EV_TOO_LONG]);
      $display("%0d plain words, capture enable toggled, sink hold-off and idling on both sides",
               event_tally[EV_NONE]);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
